/* rtl/hrp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared constants and types of the HEVC RTP packetizer.
// ----------------------------------------------------------------------------
package hrp_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_AGG = 16;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD = 3'd1;
    localparam logic [2:0] ST_NOMORE = 3'd2;
    localparam logic [2:0] ST_OOM = 3'd3;
    localparam logic [2:0] ST_MALFORMED = 3'd4;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_AGG = 2'd2;
    localparam logic [1:0] KIND_FRAG = 2'd3;

    localparam logic [5:0] TYPE_AP = 6'd48;
    localparam logic [5:0] TYPE_FU = 6'd49;
    localparam logic [7:0] TID_INIT = 8'hFF;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  kind;
        logic [7:0]  ph0;
        logic [7:0]  ph1;
        logic [7:0]  fu;
        logic [3:0]  slot;
        logic [15:0] off;
        logic [15:0] len;
        logic [15:0] plen;
        logic        last;
    } result_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;     // latch the input item
        logic push;        // store descriptor at head
        logic scan_start;  // reset aggregation scan
        logic scan_step;   // add the unit at the scan slot
        logic emit_start;  // rewind emit pointer
        logic pop;         // advance tail
        logic frag_do;     // apply fragment step
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic op;
        logic short_len;
        logic full;
        logic cap_small;
        logic cap_le3;     // capacity leaves no room for fragment data
        logic empty;
        logic fragmenting;
        logic fits_single;
        logic scan_fits;   // next unit fits and scan limit not hit
        logic emit_done;   // emitting the last aggregated unit
        logic agg_multi;   // more than one unit aggregated
    } stat_t;
endpackage
`default_nettype wire

/* rtl/hevc_rtp_packetizer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hevc_rtp_packetizer_unit
// HEVC RTP packetizer at descriptor level: ring of NAL unit descriptors and
// generation of single, aggregation and fragment packet descriptors.
// ----------------------------------------------------------------------------
// Usage: the slave channel takes one beat per command; s_tdata packs op,
// nalu_length, header_first, header_second and capacity. The master channel
// returns one beat per result segment, tlast on the final beat of a command.
// A single or aggregation request scans the ring one stored length per
// cycle (up to 16 units), then delivers one beat per cycle while the
// receiver accepts. One command is in work at a time; s_tready is high
// only while idle. A stalled receiver holds the output register and the
// sequencer waits. Reset clears the ring pointers, count and fragment
// state; the descriptor stores are not cleared.
// ----------------------------------------------------------------------------
module hevc_rtp_packetizer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op[0], nalu_length[16:1], header_first[24:17], header_second[32:25],
    // capacity[48:33], zero fill
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], kind[4:3], payload_header_first[12:5],
    // payload_header_second[20:13], fu_header[28:21], nalu_slot[32:29],
    // data_offset[48:33], data_length[64:49], packet_length[80:65], zero fill
    output logic [87:0]      m_tdata,
    output logic             m_tlast
);
    import hrp_pkg::*;

    cmd_t    cmd;
    stat_t   stat;
    result_t res, out_res;
    logic [2:0] res_sel;

    hrp_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_item(s_tdata[48:0]),
        .cmd(cmd), .res_sel(res_sel), .stat(stat), .res(res)
    );

    hrp_control u_ctl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .stat(stat), .res(res),
        .cmd(cmd), .res_sel(res_sel), .out_res(out_res)
    );

    assign m_tdata = {7'd0, out_res.plen, out_res.len, out_res.off, out_res.slot,
                      out_res.fu, out_res.ph1, out_res.ph0, out_res.kind,
                      out_res.status};
    assign m_tlast = out_res.last;
endmodule
`default_nettype wire

/* rtl/hrp_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_datapath
// Descriptor ring, aggregation scan, fragment state and result formatting.
// ----------------------------------------------------------------------------
module hrp_datapath (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [48:0]   in_item,
    input  wire hrp_pkg::cmd_t cmd,
    input  wire logic [2:0]    res_sel,
    output hrp_pkg::stat_t     stat,
    output hrp_pkg::result_t   res
);
    import hrp_pkg::*;

    localparam logic [2:0] R_ERR_BAD = 3'd0;
    localparam logic [2:0] R_ERR_NOMORE = 3'd1;
    localparam logic [2:0] R_ERR_OOM = 3'd2;
    localparam logic [2:0] R_ERR_MAL = 3'd3;
    localparam logic [2:0] R_ADD = 3'd4;
    localparam logic [2:0] R_SINGLE = 3'd5;
    localparam logic [2:0] R_AGG = 3'd6;
    localparam logic [2:0] R_FRAG = 3'd7;

    logic [15:0] len_mem [QUEUE_DEPTH];
    logic [15:0] hdr_mem [QUEUE_DEPTH];

    logic        op_reg;
    logic [15:0] nlen_reg, cap_reg;
    logic [15:0] hdr_in_reg;
    logic [SLOT_W-1:0] head_reg, tail_reg, scan_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [4:0]  nagg_reg, iter_reg, emit_reg;
    logic [16:0] total_reg;
    logic        f_reg;
    logic [2:0]  tid_reg;
    logic        frag_reg;
    logic [15:0] foff_reg, frem_reg, fph_reg;
    logic [5:0]  ftype_reg;
    logic        fstart_reg;
    logic [15:0] fsend_reg;
    logic        fend_reg;

    function automatic logic [SLOT_W-1:0] nxt(input logic [SLOT_W-1:0] s);
        if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    logic [15:0] tail_len, scan_len;
    logic [15:0] tail_hdr, scan_hdr;
    assign tail_len = len_mem[tail_reg];
    assign tail_hdr = hdr_mem[tail_reg];
    assign scan_len = len_mem[scan_reg];
    assign scan_hdr = hdr_mem[scan_reg];

    logic [4:0]  limit;
    logic [17:0] trial;
    logic [15:0] maxd;
    assign limit = (count_reg < CNT_W'(MAX_AGG)) ? 5'(count_reg) : 5'(MAX_AGG);
    assign trial = {1'b0, total_reg} + 18'd2 + {2'b0, scan_len};
    assign maxd = cap_reg - 16'd3;

    always_comb begin
        stat.op = op_reg;
        stat.short_len = nlen_reg < 16'd2;
        stat.full = count_reg >= CNT_W'(QUEUE_DEPTH);
        stat.cap_small = cap_reg < 16'd3;
        stat.cap_le3 = cap_reg <= 16'd3;
        stat.empty = count_reg == '0;
        stat.fragmenting = frag_reg;
        stat.fits_single = tail_len <= cap_reg;
        stat.scan_fits = (iter_reg < limit) && (trial <= {2'b0, cap_reg});
        stat.emit_done = (emit_reg + 5'd1) == nagg_reg;
        stat.agg_multi = nagg_reg > 5'd1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            len_mem[head_reg] <= nlen_reg;
            hdr_mem[head_reg] <= hdr_in_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= in_item[0];
            nlen_reg <= in_item[16:1];
            hdr_in_reg <= {in_item[24:17], in_item[32:25]};
            cap_reg <= in_item[48:33];
        end
        if (cmd.scan_start) begin
            scan_reg <= tail_reg;
            iter_reg <= '0;
            nagg_reg <= '0;
            total_reg <= 17'd2;
            f_reg <= 1'b0;
            tid_reg <= 3'd7;
        end else if (cmd.scan_step) begin
            scan_reg <= nxt(scan_reg);
            iter_reg <= iter_reg + 5'd1;
            nagg_reg <= nagg_reg + 5'd1;
            total_reg <= trial[16:0];
            f_reg <= f_reg | scan_hdr[15];
            if (scan_hdr[2:0] < tid_reg) begin
                tid_reg <= scan_hdr[2:0];
            end
        end
        if (cmd.emit_start) begin
            emit_reg <= '0;
        end else if (cmd.pop) begin
            emit_reg <= emit_reg + 5'd1;
        end
    end

    // Fragment step: next-state of the fragment registers from one request.
    logic [15:0] f_off_c, f_rem_c, f_ph_c;
    logic [5:0]  f_type_c;
    logic [15:0] f_send_c;
    always_comb begin
        if (frag_reg) begin
            f_off_c = foff_reg;
            f_rem_c = frem_reg;
            f_ph_c = fph_reg;
            f_type_c = ftype_reg;
        end else begin
            f_off_c = 16'd2;
            f_rem_c = tail_len - 16'd2;
            f_ph_c = {tail_hdr[15], TYPE_FU, 1'b0, 5'd0, tail_hdr[2:0]};
            f_type_c = tail_hdr[14:9];
        end
        f_send_c = (maxd < f_rem_c) ? maxd : f_rem_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
            frag_reg <= 1'b0;
            foff_reg <= '0;
            frem_reg <= '0;
            fph_reg <= '0;
            ftype_reg <= '0;
        end else begin
            if (cmd.push) begin
                head_reg <= nxt(head_reg);
            end
            if (cmd.pop) begin
                tail_reg <= nxt(tail_reg);
            end
            if (cmd.push && !cmd.pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.pop && !cmd.push) begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.frag_do) begin
                fstart_reg <= !frag_reg;
                fsend_reg <= f_send_c;
                fend_reg <= f_send_c == f_rem_c;
                fph_reg <= f_ph_c;
                ftype_reg <= f_type_c;
                foff_reg <= f_off_c + f_send_c;
                frem_reg <= f_rem_c - f_send_c;
                frag_reg <= 1'b1;
            end else if (cmd.pop && frag_reg) begin
                frag_reg <= 1'b0;
                foff_reg <= '0;
                fph_reg <= '0;
                ftype_reg <= '0;
            end
        end
    end

    always_comb begin
        res = '0;
        res.last = 1'b1;
        case (res_sel)
            R_ERR_BAD: res.status = ST_BAD;
            R_ERR_NOMORE: res.status = ST_NOMORE;
            R_ERR_OOM: res.status = ST_OOM;
            R_ERR_MAL: res.status = ST_MALFORMED;
            R_ADD: res.slot = 4'(head_reg);
            R_SINGLE: begin
                res.kind = KIND_SINGLE;
                res.slot = 4'(tail_reg);
                res.len = tail_len;
                res.plen = tail_len;
            end
            R_AGG: begin
                res.kind = KIND_AGG;
                res.ph0 = {f_reg, TYPE_AP, 1'b0};
                res.ph1 = {5'd0, tid_reg};
                res.slot = 4'(tail_reg);
                res.len = tail_len;
                res.plen = total_reg[15:0];
                res.last = (emit_reg + 5'd1) == nagg_reg;
            end
            R_FRAG: begin
                res.kind = KIND_FRAG;
                res.ph0 = fph_reg[15:8];
                res.ph1 = fph_reg[7:0];
                res.fu = {fstart_reg, fend_reg, ftype_reg};
                res.slot = 4'(tail_reg);
                res.off = foff_reg - fsend_reg;
                res.len = fsend_reg;
                res.plen = fsend_reg + 16'd3;
            end
            default: res = '0;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/hrp_control.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_control
// Sequencer for adds and packet requests, and the result output register.
// ----------------------------------------------------------------------------
module hrp_control (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire hrp_pkg::stat_t   stat,
    input  wire hrp_pkg::result_t res,
    output hrp_pkg::cmd_t         cmd,
    output logic [2:0]            res_sel,
    output hrp_pkg::result_t      out_res
);
    import hrp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_AGG = 3'd3;
    localparam logic [2:0] S_FRAG = 3'd4;
    localparam logic [2:0] S_HOLD = 3'd5;

    localparam logic [2:0] R_ERR_BAD = 3'd0;
    localparam logic [2:0] R_ERR_NOMORE = 3'd1;
    localparam logic [2:0] R_ERR_OOM = 3'd2;
    localparam logic [2:0] R_ERR_MAL = 3'd3;
    localparam logic [2:0] R_ADD = 3'd4;
    localparam logic [2:0] R_SINGLE = 3'd5;
    localparam logic [2:0] R_AGG = 3'd6;
    localparam logic [2:0] R_FRAG = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       load;
    logic       space;
    logic       frag_end;

    // A new result may be loaded when the output register is empty or drains.
    assign space = !out_valid || out_ready;
    assign in_ready = state_reg == S_IDLE;
    assign frag_end = res.fu[6];

    always_comb begin
        cmd = '0;
        res_sel = R_ADD;
        load = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (space) begin
                    if (!stat.op) begin
                        load = 1'b1;
                        state_next = S_IDLE;
                        if (stat.short_len) begin
                            res_sel = R_ERR_MAL;
                        end else if (stat.full) begin
                            res_sel = R_ERR_OOM;
                        end else begin
                            res_sel = R_ADD;
                            cmd.push = 1'b1;
                        end
                    end else if (stat.cap_small) begin
                        load = 1'b1;
                        res_sel = R_ERR_BAD;
                        state_next = S_IDLE;
                    end else if (stat.empty) begin
                        load = 1'b1;
                        res_sel = R_ERR_NOMORE;
                        state_next = S_IDLE;
                    end else if (stat.fragmenting || !stat.fits_single) begin
                        state_next = S_FRAG;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (stat.scan_fits) begin
                    cmd.scan_step = 1'b1;
                end else begin
                    cmd.emit_start = 1'b1;
                    state_next = S_AGG;
                end
            end
            S_AGG: begin
                if (space) begin
                    load = 1'b1;
                    cmd.pop = 1'b1;
                    if (stat.agg_multi) begin
                        res_sel = R_AGG;
                        if (stat.emit_done) begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        res_sel = R_SINGLE;
                        state_next = S_IDLE;
                    end
                end
            end
            S_FRAG: begin
                // Capacity was checked at least 3; a fragment needs more.
                if (space) begin
                    if (stat.cap_le3) begin
                        load = 1'b1;
                        res_sel = R_ERR_OOM;
                        state_next = S_IDLE;
                    end else begin
                        cmd.frag_do = 1'b1;
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (space) begin
                    load = 1'b1;
                    res_sel = R_FRAG;
                    cmd.pop = frag_end;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                out_valid <= 1'b1;
            end else if (out_ready) begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_res <= res;
        end
    end
endmodule
`default_nettype wire
